>>> rtl/ked_pkg.sv
// ----------------------------------------------------------------------------
// ked_pkg
// Shared types and constants for the k-mer edit distance block.
// ----------------------------------------------------------------------------
package ked_pkg;

  localparam int MAX_BASES_DEF = 32;

  localparam int CFG_W       = 6;    // width of both configuration registers
  localparam int CFG_AW      = 2;    // configuration index width
  localparam int DIST_W      = 6;    // result distance width
  localparam int IN_TDATA_W  = 128;  // two 64-bit k-mers
  localparam int OUT_TDATA_W = 8;    // distance + flag, padded to a byte

  localparam logic [CFG_AW-1:0] REG_KMER_LENGTH    = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DISTANCE_LIMIT = 2'd1;

  localparam logic [CFG_W-1:0] KMER_LENGTH_RST    = 6'd32;
  localparam logic [CFG_W-1:0] DISTANCE_LIMIT_RST = 6'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // controller -> datapath / output stage
  typedef struct packed {
    logic load;   // capture k-mers, start wavefront
    logic step;   // advance one anti-diagonal
    logic latch;  // capture the result
    logic push;   // move the result to the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fin;    // result is ready on this step
  } ctrl_sts_t;

endpackage

>>> rtl/ked_ctrl.sv
// ----------------------------------------------------------------------------
// ked_ctrl
// Sequencer for the edit distance block: accept, sweep, hand over result.
// ----------------------------------------------------------------------------
module ked_ctrl
  import ked_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       out_free,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.fin) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_RUN: begin
        cmd.step  = 1'b1;
        cmd.latch = sts.fin;
      end
      ST_DONE: begin
        cmd.push  = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/ked_datapath.sv
// ----------------------------------------------------------------------------
// ked_datapath
// Anti-diagonal wavefront over the edit distance table, one lane per row.
// ----------------------------------------------------------------------------
module ked_datapath
  import ked_pkg::*;
#(
  parameter int MAX_BASES = MAX_BASES_DEF
) (
  input  logic                 clk,
  input  ctrl_cmd_t            cmd,
  input  logic [63:0]          first_kmer,
  input  logic [63:0]          second_kmer,
  input  logic [CFG_W-1:0]     kmer_len,
  input  logic [CFG_W-1:0]     dist_limit,
  output ctrl_sts_t            sts,
  output logic [DIST_W-1:0]    res_dist,
  output logic                 res_within
);

  // cell values reach at most 2*MAX_BASES (row 0 counts up to the last step)
  localparam int DW = $clog2(2 * MAX_BASES + 1);
  localparam int LW = $clog2(MAX_BASES + 1);
  localparam int AW = 2 * MAX_BASES;

  logic [AW-1:0]   a_r;
  logic [AW+1:0]   b_sr_r;
  logic [DW-1:0]   d_r;
  logic [DW-1:0]   cur_r   [0:MAX_BASES];
  logic [DW-1:0]   prev2_r [0:MAX_BASES];
  logic [1:0]      bq_r    [1:MAX_BASES];
  logic [DW-1:0]   cur_nxt [0:MAX_BASES];
  logic [1:0]      bsel    [1:MAX_BASES];
  logic [DIST_W-1:0] res_dist_r;
  logic              res_within_r;

  logic [LW-1:0]   k_eff;
  logic [LW-1:0]   half;
  logic [DW-1:0]   diag_val;
  logic [DW-1:0]   res_full;

  function automatic logic [DW-1:0] min3(input logic [DW-1:0] x,
                                         input logic [DW-1:0] y,
                                         input logic [DW-1:0] z);
    logic [DW-1:0] m;
    m = (x < y) ? x : y;
    return (m < z) ? m : z;
  endfunction

  assign k_eff = (kmer_len > CFG_W'(MAX_BASES)) ? LW'(MAX_BASES) : LW'(kmer_len);
  assign half  = d_r[DW-1:1];

  // one cell per lane on the current anti-diagonal; lane i sits at column d-i
  always_comb begin
    cur_nxt[0] = cur_r[0] + DW'(1);
    for (int i = 1; i <= MAX_BASES; i++) begin
      bsel[i] = (i == 1) ? b_sr_r[1:0] : bq_r[(i > 1) ? i - 1 : 1];
      if (d_r == DW'(i)) begin
        cur_nxt[i] = DW'(i);  // column zero
      end else begin
        cur_nxt[i] = min3(prev2_r[i-1] + DW'(a_r[2*(i-1) +: 2] != bsel[i]),
                          cur_r[i-1] + DW'(1),
                          cur_r[i] + DW'(1));
      end
    end
  end

  // cell (i,i) lies on anti-diagonal 2i and is produced by lane i
  assign diag_val = cur_nxt[half];
  assign sts.fin  = (k_eff == '0) ||
                    (!d_r[0] && ((diag_val > DW'(dist_limit)) || (half == k_eff)));
  assign res_full = (k_eff == '0) ? '0 : diag_val;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r      <= first_kmer[AW-1:0];
      b_sr_r   <= {second_kmer[AW-1:0], 2'b00};
      cur_r[0] <= '0;
      d_r      <= DW'(1);
    end else if (cmd.step) begin
      for (int i = 0; i <= MAX_BASES; i++) begin
        cur_r[i]   <= cur_nxt[i];
        prev2_r[i] <= cur_r[i];
      end
      for (int i = 1; i <= MAX_BASES; i++) begin
        bq_r[i] <= bsel[i];
      end
      b_sr_r <= b_sr_r >> 2;
      d_r    <= d_r + DW'(1);
    end
    if (cmd.latch) begin
      res_dist_r   <= res_full[DIST_W-1:0];
      res_within_r <= (res_full <= DW'(dist_limit));
    end
  end

  assign res_dist   = res_dist_r;
  assign res_within = res_within_r;

endmodule

>>> rtl/kmer_edit_distance_early_exit.sv
// ----------------------------------------------------------------------------
// kmer_edit_distance_early_exit
// Unit-cost edit distance of two packed k-mers, with early exit on the diagonal.
// ----------------------------------------------------------------------------
// Usage notes:
//  - in_* carries one transaction per pair of k-mers, 2 bits per base, base 0
//    in the low bits. out_* returns one transaction per pair: the distance,
//    and a flag set when it is no greater than distance_limit.
//  - cfg_* writes kmer_length (index 0) and distance_limit (index 1); only
//    write while no pair is in flight. Lengths above MAX_BASES saturate.
//  - The table is swept by anti-diagonals, one per cycle, with one lane per
//    row. A pair is accepted in idle, swept, then handed to the output
//    register before the next pair is taken. If the diagonal cell (i,i)
//    exceeds the limit the sweep stops once that cell is produced. k = 0
//    ends the sweep on its first step with distance 0.
//  - out_tvalid rises on the same edge at which the controller returns to
//    idle, ready for the next pair.
//  - The output register holds the finished result; a new pair is accepted
//    while it waits. A second result is kept in the datapath until the
//    receiver takes the first, and input is held off meanwhile.
//  - Reset (synchronous, active low) returns to idle, clears out_tvalid and
//    restores kmer_length = 32 and distance_limit = 1.
// ----------------------------------------------------------------------------
module kmer_edit_distance_early_exit
  import ked_pkg::*;
#(
  parameter int MAX_BASES = MAX_BASES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [63:0] first_kmer, [127:64] second_kmer
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [5:0] distance, [6] within_limit, [7] zero
);

  logic [CFG_W-1:0]       kmer_length_r;
  logic [CFG_W-1:0]       distance_limit_r;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_free;
  ctrl_cmd_t              cmd;
  ctrl_sts_t              sts;
  logic [DIST_W-1:0]      res_dist;
  logic                   res_within;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r    <= KMER_LENGTH_RST;
      distance_limit_r <= DISTANCE_LIMIT_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_KMER_LENGTH)    kmer_length_r    <= cfg_wdata;
      if (cfg_addr == REG_DISTANCE_LIMIT) distance_limit_r <= cfg_wdata;
    end
  end

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_tvalid_r || out_tready;

  ked_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_free  (out_free),
    .sts       (sts),
    .cmd       (cmd)
  );

  ked_datapath #(
    .MAX_BASES (MAX_BASES)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .first_kmer  (in_tdata[63:0]),
    .second_kmer (in_tdata[127:64]),
    .kmer_len    (kmer_length_r),
    .dist_limit  (distance_limit_r),
    .sts         (sts),
    .res_dist    (res_dist),
    .res_within  (res_within)
  );

  // output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.push)        out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_tdata_r <= {1'b0, res_within, res_dist};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> rtl/ked_checker.sv
// ----------------------------------------------------------------------------
// ked_checker
// Port-level checks for the k-mer edit distance block, bound to the top level.
// ----------------------------------------------------------------------------
module ked_checker
  import ked_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata
);

  // nothing is left on the output after reset
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one pair at a time: no acceptance on the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // distance never above the longest k-mer, padding bit zero
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] <= 6'd32) && !out_tdata[7])
    else $error("distance out of range");

  // a zero distance is always within the limit
  a_zero_within: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[5:0] == 6'd0) |-> out_tdata[6])
    else $error("zero distance flagged over limit");

endmodule

bind kmer_edit_distance_early_exit ked_checker u_ked_checker (.*);

>>> tb/sv/ked_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ked_tb_pkg
// Distance predictor and result scoreboard for the k-mer edit distance bench.
// ----------------------------------------------------------------------------
package ked_tb_pkg;
  import ked_pkg::*;

  localparam int TB_MAX_BASES = 32;
  localparam int MAX_PRINTED  = 30;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              within_limit;
  } ked_result_t;

  class ked_scoreboard;
    logic [CFG_W-1:0] kmer_length;
    logic [CFG_W-1:0] distance_limit;
    ked_result_t      expected_q[$];
    int unsigned      mismatches;
    int unsigned      pairs_seen;
    int unsigned      results_seen;
    int unsigned      early_exits;

    function new();
      kmer_length    = KMER_LENGTH_RST;
      distance_limit = DISTANCE_LIMIT_RST;
      mismatches     = 0;
      pairs_seen     = 0;
      results_seen   = 0;
      early_exits    = 0;
    endfunction

    // one line per mismatch; printing is capped, counting is not
    task report(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // spare indexes fall through and change nothing
    function void write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] value);
      case (addr)
        REG_KMER_LENGTH:    kmer_length    = value;
        REG_DISTANCE_LIMIT: distance_limit = value;
        default: ;
      endcase
    endfunction

    // Row-by-row table; stops once diagonal cell (i,i) is above the limit
    function logic [DIST_W-1:0] edit_distance(input logic [63:0] a, input logic [63:0] b,
                                               output bit exited);
      int          prev[TB_MAX_BASES+1];
      int          cur[TB_MAX_BASES+1];
      int          k, lim, i, j, best;
      logic [1:0]  base_a;
      k      = (kmer_length > TB_MAX_BASES) ? TB_MAX_BASES : int'(kmer_length);
      lim    = int'(distance_limit);
      exited = 1'b0;
      for (j = 0; j <= k; j++)
        prev[j] = j;
      for (i = 1; i <= k; i++) begin
        base_a = a[2*(i-1) +: 2];
        cur[0] = i;
        for (j = 1; j <= k; j++) begin
          best = prev[j-1] + ((base_a != b[2*(j-1) +: 2]) ? 1 : 0);
          if (prev[j] + 1 < best)
            best = prev[j] + 1;
          if (cur[j-1] + 1 < best)
            best = cur[j-1] + 1;
          cur[j] = best;
        end
        if (cur[i] > lim) begin
          exited = 1'b1;
          return DIST_W'(cur[i]);
        end
        prev = cur;
      end
      return DIST_W'(prev[k]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // accepted input transaction: work out and queue its result
    function void note_pair(input logic [IN_TDATA_W-1:0] tdata);
      ked_result_t want;
      bit          exited;
      want.distance     = edit_distance(tdata[63:0], tdata[127:64], exited);
      want.within_limit = (want.distance <= distance_limit);
      expected_q = {expected_q, want};
      pairs_seen++;
      if (exited)
        early_exits++;
    endfunction

    // accepted result transaction: compare with the oldest expectation
    task check_result(input logic [OUT_TDATA_W-1:0] tdata);
      ked_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0h arrived with nothing expected", tdata));
        return;
      end
      want = expected_q.pop_front();
      if (tdata[DIST_W-1:0] !== want.distance)
        report($sformatf("distance %0d, expected %0d", tdata[DIST_W-1:0], want.distance));
      if (tdata[DIST_W] !== want.within_limit)
        report($sformatf("within_limit %b, expected %b", tdata[DIST_W], want.within_limit));
      if (tdata[OUT_TDATA_W-1] !== 1'b0)
        report($sformatf("padding bit %b, expected 0", tdata[OUT_TDATA_W-1]));
    endtask

    task flush_leftovers();
      while (expected_q.size() != 0) begin
        report($sformatf("distance %0d never returned", expected_q[0].distance));
        void'(expected_q.pop_front());
      end
    endtask
  endclass

endpackage

>>> tb/sv/tb_kmer_edit_distance_early_exit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kmer_edit_distance_early_exit
// Drives k-mer pairs through the edit distance block under a series of
// length/limit settings, predicts every distance and flag, checks each result.
// ----------------------------------------------------------------------------
module tb_kmer_edit_distance_early_exit;
  import ked_pkg::*;
  import ked_tb_pkg::*;

  // Run shape
  localparam int N_PHASES       = 12;
  localparam int PAIRS_PER_PHASE = 80;
  localparam int SETTLE_CYCLES  = 2 * MAX_BASES_DEF + 4;  // one full sweep plus margin
  localparam int RUN_LIMIT_NS   = 2_000_000;

  // Unused register indexes; writes there must have no effect
  localparam logic [CFG_AW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_AW-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {EDIT_SUB, EDIT_INS, EDIT_DEL} edit_kind_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr   = '0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [63:0] first_kmer, [127:64] second_kmer
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [5:0] distance, [6] within_limit, [7] zero

  // Idling control, shared by the input driver and the result stall process
  bit idle_on  = 1'b0;
  int idle_pct = 0;

  ked_scoreboard sb = new();

  // Length/limit per phase. Phase 0 keeps the reset values; the last three
  // are drawn at random when reached.
  int phase_len[N_PHASES] = '{32, 0, 1, 32, 63, 33, 8, 16, 5, 20, 32, 12};
  int phase_lim[N_PHASES] = '{ 1, 1, 0, 32, 63,  2, 3,  0, 40, 4,  5,  2};

  kmer_edit_distance_early_exit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Transaction monitors. Values are sampled as they stood at the edge; the
  // result is checked before a new pair is noted so a spurious result on the
  // same edge cannot steal that pair's expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
    if (rst_n && in_tvalid && in_tready)
      sb.note_pair(in_tdata);
  end

  // Receiver back-pressure: stalled bursts of random length while idling is on
  always begin
    @(posedge clk);
    if (idle_on && rst_n && $urandom_range(0, 99) < idle_pct) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  function automatic int pick_gap();
    if (idle_on && $urandom_range(0, 99) < idle_pct)
      return $urandom_range(1, 9);
    return 0;
  endfunction

  // Apply a few random edits within the first k bases
  function automatic logic [63:0] mutate_kmer(input logic [63:0] src, input int k,
                                              input int edits);
    logic [63:0] dst;
    int          pos, p, n;
    dst = src;
    if (k == 0)
      return dst;
    for (n = 0; n < edits; n++) begin
      pos = $urandom_range(0, k - 1);
      case (edit_kind_t'($urandom_range(0, 2)))
        EDIT_SUB: dst[2*pos +: 2] = dst[2*pos +: 2] + 2'($urandom_range(1, 3));
        EDIT_INS: begin
          for (p = k - 1; p > pos; p--)
            dst[2*p +: 2] = dst[2*(p-1) +: 2];
          dst[2*pos +: 2] = 2'($urandom);
        end
        default: begin
          for (p = pos; p < k - 1; p++)
            dst[2*p +: 2] = dst[2*(p+1) +: 2];
          dst[2*(k-1) +: 2] = 2'($urandom);
        end
      endcase
    end
    return dst;
  endfunction

  // Fill bits at or above 2k with noise; the block must ignore them
  function automatic logic [63:0] scramble_upper(input logic [63:0] kmer, input int k);
    logic [63:0] mask;
    mask = (k >= TB_MAX_BASES) ? 64'd0 : ({64{1'b1}} << (2 * k));
    return (kmer & ~mask) | ({$urandom, $urandom} & mask);
  endfunction

  // One input transaction, with an optional idle burst ahead of it.
  // Valid stays high from one pair to the next when no gap is drawn.
  task automatic send_pair(input logic [63:0] first_kmer, input logic [63:0] second_kmer);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {second_kmer, first_kmer};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Leaves cfg_we high; configure lowers it after the last write
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(addr, value);
  endtask

  task automatic configure(input int length, input int limit);
    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
    write_reg(REG_KMER_LENGTH, CFG_W'(length));
    write_reg(REG_DISTANCE_LIMIT, CFG_W'(limit));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending, wait for every outstanding result, then let a full sweep
  // pass so nothing stray is still in flight.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          p, n, k_eff, pick;
    logic [63:0] a, b, pattern;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (p = 0; p < N_PHASES; p++) begin
      if (p >= N_PHASES - 3) begin
        phase_len[p] = $urandom_range(1, 32);
        phase_lim[p] = $urandom_range(0, 6);
      end
      // no idling at all during the final phase
      idle_on = (p != N_PHASES - 1);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 25;
        default: idle_pct = 60;
      endcase
      if (p != 0)
        configure(phase_len[p], phase_lim[p]);
      k_eff = (phase_len[p] > TB_MAX_BASES) ? TB_MAX_BASES : phase_len[p];

      // Directed pairs for the settings of interest
      case (p)
        0: begin  // reset settings: k = 32, limit 1
          pattern = {$urandom, $urandom};
          send_pair('0, '0);
          send_pair('1, '1);
          send_pair('0, '1);                      // early exit on row 2
          send_pair('1, '0);
          send_pair(pattern, pattern);
          send_pair(pattern, pattern ^ 64'h3);    // substitution, first base
          send_pair(pattern, pattern ^ (64'h1 << 62));  // substitution, last base
          send_pair(pattern, pattern ^ 64'h0000_0100_0000_0002);  // two far apart
          send_pair(pattern, pattern >> 2);       // one-base shift
          send_pair({32{2'b01}}, {32{2'b10}});
          send_pair(pattern, mutate_kmer(pattern, 32, 1));
          send_pair(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        end
        1: begin  // zero length: always distance 0
          send_pair('0, '1);
          send_pair({$urandom, $urandom}, {$urandom, $urandom});
        end
        2: begin  // single base, limit 0
          send_pair(64'h0, 64'h1);
          send_pair(64'h8, 64'hfffffff0_0000_0000);  // equal base 0, noise above
        end
        3: send_pair('0, '1);   // limit 32: no early exit, full distance
        4: send_pair('1, '0);   // length saturates, limit above any distance
        default: ;
      endcase

      // Random pairs: mostly near-identical k-mers so the sweep runs deep
      for (n = 0; n < PAIRS_PER_PHASE; n++) begin
        a    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 60)
          b = mutate_kmer(a, k_eff, $urandom_range(1, 4));
        else if (pick < 80)
          b = {$urandom, $urandom};
        else if (pick < 90)
          b = a;
        else begin
          a = $urandom_range(0, 1) ? '1 : '0;
          b = $urandom_range(0, 1) ? '1 : '0;
        end
        send_pair(scramble_upper(a, k_eff), scramble_upper(b, k_eff));
      end

      drain();
    end

    sb.flush_leftovers();
    $display("Covered %0d pairs over %0d length/limit settings, %0d ending early.",
             sb.pairs_seen, N_PHASES, sb.early_exits);
    $display("Checked %0d results, %0d mismatches.", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0)
      $display("tb_kmer_edit_distance_early_exit passed");
    else
      $display("tb_kmer_edit_distance_early_exit failed");
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout: results still outstanding");
    $display("tb_kmer_edit_distance_early_exit failed");
    $finish;
  end

endmodule

>>> kmer_edit_distance_early_exit.f
rtl/ked_pkg.sv
rtl/ked_ctrl.sv
rtl/ked_datapath.sv
rtl/kmer_edit_distance_early_exit.sv
rtl/ked_checker.sv
tb/sv/ked_tb_pkg.sv
tb/sv/tb_kmer_edit_distance_early_exit.sv
